// File: hdl/rrtns_pkg.sv
`timescale 1ns / 1ps
package rrtns_pkg;
	localparam int COORD_BITS = 24;
	localparam int MAX_NODES  = 1024;
	localparam int IDX_W      = $clog2(MAX_NODES);
	localparam int CNT_W      = 11;
	localparam int STEP_W     = 16;
	localparam int NODE_W     = 3 * COORD_BITS;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int D2_W       = SQ_W + 2;
	localparam int ROOT_W     = D2_W / 2;
	localparam int DVD_W      = DIFF_W + STEP_W;
	localparam int LIM_W      = 2 * STEP_W;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [D2_W-1:0] d2_t;

	typedef enum logic [1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_QUERY  = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	// handshake of an iterative unit
	typedef struct packed {
		logic start;
	} unit_ctl_t;

	typedef struct packed {
		logic done;
	} unit_sts_t;
endpackage

// File: hdl/rrtns_ram.sv
`timescale 1ns / 1ps
module rrtns_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: hdl/rrtns_dist.sv
`timescale 1ns / 1ps
module rrtns_dist
	import rrtns_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [NODE_W-1:0] node,
	input  coord_t            smp [3],
	output logic              vld_s2,
	output logic [NODE_W-1:0] node_s2,
	output d2_t               d2
);
	logic [SQ_W-1:0] sq_s2 [3];
	logic [DIFF_W-1:0] mag [3];
	logic signed [DIFF_W-1:0] diff [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = DIFF_W'(signed'(node[i*COORD_BITS +: COORD_BITS])) - DIFF_W'(smp[i]);
			mag[i]  = diff[i][DIFF_W-1] ? DIFF_W'(-diff[i]) : DIFF_W'(diff[i]);
		end
	end

	// squares registered, sum left to the compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		node_s2 <= node;
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= mag[i] * mag[i];
		end
	end

	assign d2 = D2_W'(sq_s2[0]) + D2_W'(sq_s2[1]) + D2_W'(sq_s2[2]);
endmodule

// File: hdl/rrtns_sqrt.sv
`timescale 1ns / 1ps
module rrtns_sqrt
	import rrtns_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  unit_ctl_t         ctl,
	input  d2_t               rad,
	output unit_sts_t         sts,
	output logic [ROOT_W-1:0] root
);
	localparam int REM_W = ROOT_W + 3;
	localparam int CNT_W_L = $clog2(ROOT_W + 1);

	logic [D2_W-1:0]    rad_q;
	logic [REM_W-1:0]   rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [CNT_W_L-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [REM_W-1:0]   cand;
	logic [REM_W-1:0]   trial;
	logic               ge;

	// one result bit per cycle, restoring form
	assign cand  = {rem_q[REM_W-3:0], rad_q[D2_W-1 -: 2]};
	assign trial = REM_W'({root_q, 2'b01});
	assign ge    = cand >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W_L'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W_L'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[D2_W-3:0], 2'b00};
			rem_q  <= ge ? cand - trial : cand;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign sts.done = done_q;
	assign root     = root_q;
endmodule

// File: hdl/rrtns_div.sv
`timescale 1ns / 1ps
module rrtns_div
	import rrtns_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  unit_ctl_t         ctl,
	input  logic [DVD_W-1:0]  dividend,
	input  logic [ROOT_W-1:0] divisor,
	output unit_sts_t         sts,
	output logic [DVD_W-1:0]  quot
);
	localparam int CNT_W_L = $clog2(DVD_W + 1);

	logic [DVD_W-1:0]   dvd_q;
	logic [ROOT_W-1:0]  rem_q;
	logic [ROOT_W-1:0]  dsr_q;
	logic [CNT_W_L-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [ROOT_W:0]    trial;
	logic               ge;

	// quotient bits shift in where dividend bits leave
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W_L'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W_L'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? ROOT_W'(trial - {1'b0, dsr_q}) : ROOT_W'(trial);
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	assign sts.done = done_q;
	assign quot     = dvd_q;
endmodule

// File: hdl/rrt_nearest_node_and_steer_top.sv
`timescale 1ns / 1ps
// clear, insert, ignored requests and empty-table queries go straight to the result register;
//   a query scans all nodes, then runs the square root and per-axis divider if the sample is far
// throughput: one request at a time; the next is taken once the result is registered
// the node scan reads one ram entry per cycle, the divider is shared by the three axes
// reset (async, active low) empties the table, sets step_length to 256, clears handshakes
module rrt_nearest_node_and_steer_top
	import rrtns_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [STEP_W-1:0]  cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  coord_t             px,
	input  coord_t             py,
	input  coord_t             pz,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output coord_t             near_x,
	output coord_t             near_y,
	output coord_t             near_z,
	output coord_t             new_x,
	output coord_t             new_y,
	output coord_t             new_z,
	output logic [CNT_W-1:0]   node_count,
	output logic               dropped
);
	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_DRAIN, S_FAR, S_SQRT, S_PROD, S_MUL, S_DIVW, S_DONE
	} state_t;

	state_t             state_q;
	logic [STEP_W-1:0]  step_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   rd_idx_q;
	logic               v_s1_q;
	logic               first_q;
	coord_t             smp_q [3];
	coord_t             near_q [3];
	coord_t             new_q [3];
	d2_t                best_d_q;
	logic [LIM_W-1:0]   lim_q;
	logic [ROOT_W-1:0]  root_q;
	logic [1:0]         axis_q;
	logic [DVD_W-1:0]   prod_q;
	logic               neg_q;
	logic               found_q;
	logic               dropped_q;

	logic               accept;
	logic               full;
	logic               query_hit;
	logic               insert_drop;
	logic               ram_we;
	logic               ram_re;
	logic [NODE_W-1:0]  ram_rdata;
	logic               dv_s2;
	logic [NODE_W-1:0]  node_s2;
	d2_t                d2;
	unit_ctl_t          sqrt_ctl;
	unit_sts_t          sqrt_sts;
	unit_ctl_t          div_ctl;
	unit_sts_t          div_sts;
	logic [DVD_W-1:0]   quot;
	logic signed [DIFF_W-1:0] axis_diff;
	logic [DIFF_W-1:0]  axis_mag;
	logic signed [DIFF_W-1:0] step_off;
	logic               out_free;

	assign accept      = in_valid && !in_stall;
	assign in_stall    = (state_q != S_IDLE);
	assign full        = (count_q == CNT_W'(MAX_NODES));
	assign query_hit   = (req_t'(req_type) == REQ_QUERY) && (count_q != '0);
	assign insert_drop = (req_t'(req_type) == REQ_INSERT) && full;
	assign ram_we      = accept && (req_t'(req_type) == REQ_INSERT) && !full;
	assign ram_re      = (state_q == S_SCAN);
	assign out_free    = !out_valid || !out_stall;

	// node table, one entry of x, y, z per insert
	rrtns_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata ({pz, py, px}),
		.re    (ram_re),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	// squared distance, pipelined one node per cycle
	rrtns_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (v_s1_q),
		.node    (ram_rdata),
		.smp     (smp_q),
		.vld_s2  (dv_s2),
		.node_s2 (node_s2),
		.d2      (d2)
	);

	assign sqrt_ctl.start = (state_q == S_FAR) && (D2_W'(lim_q) < best_d_q);

	rrtns_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sqrt_ctl),
		.rad    (best_d_q),
		.sts    (sqrt_sts),
		.root   (root_q)
	);

	// divider shared by the three axes, started once the product is registered
	assign div_ctl.start = (state_q == S_MUL);

	rrtns_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (prod_q),
		.divisor  (root_q),
		.sts      (div_sts),
		.quot     (quot)
	);

	// offset of the sample from the nearest node on the current axis
	assign axis_diff = DIFF_W'(smp_q[axis_q]) - DIFF_W'(near_q[axis_q]);
	assign axis_mag  = axis_diff[DIFF_W-1] ? DIFF_W'(-axis_diff) : DIFF_W'(axis_diff);
	assign step_off  = neg_q ? -signed'(quot[DIFF_W-1:0]) : signed'(quot[DIFF_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			step_q     <= STEP_W'(256);
			count_q    <= '0;
			rd_idx_q   <= '0;
			v_s1_q     <= 1'b0;
			first_q    <= 1'b0;
			axis_q     <= '0;
			best_d_q   <= '0;
			lim_q      <= '0;
			prod_q     <= '0;
			neg_q      <= 1'b0;
			found_q    <= 1'b0;
			dropped_q  <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				smp_q[i]  <= '0;
				near_q[i] <= '0;
				new_q[i]  <= '0;
			end
			out_valid  <= 1'b0;
			found      <= 1'b0;
			near_x     <= '0;
			near_y     <= '0;
			near_z     <= '0;
			new_x      <= '0;
			new_y      <= '0;
			new_z      <= '0;
			node_count <= '0;
			dropped    <= 1'b0;
		end else begin
			if (cfg_we) begin
				step_q <= cfg_wdata;
			end
			v_s1_q <= ram_re;
			// a new result in S_DONE takes over the register instead
			if (out_valid && !out_stall && (state_q != S_DONE)) begin
				out_valid <= 1'b0;
			end

			// best node so far, strict compare keeps the earlier node on a tie
			if (dv_s2) begin
				first_q <= 1'b0;
				if (first_q || (d2 < best_d_q)) begin
					best_d_q <= d2;
					for (int i = 0; i < 3; i++) begin
						near_q[i] <= node_s2[i*COORD_BITS +: COORD_BITS];
					end
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						found_q   <= query_hit;
						dropped_q <= insert_drop;
						smp_q[0]  <= px;
						smp_q[1]  <= py;
						smp_q[2]  <= pz;
						lim_q     <= step_q * step_q;
						rd_idx_q  <= '0;
						first_q   <= 1'b1;
						axis_q    <= '0;
						for (int i = 0; i < 3; i++) begin
							near_q[i] <= '0;
							new_q[i]  <= '0;
						end
						state_q <= query_hit ? S_SCAN : S_DONE;
						unique case (req_t'(req_type))
							REQ_CLEAR: begin
								count_q <= '0;
							end
							REQ_INSERT: begin
								if (!full) begin
									count_q <= count_q + 1'b1;
								end
							end
							REQ_QUERY, REQ_NONE: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					rd_idx_q <= rd_idx_q + 1'b1;
					if ({1'b0, rd_idx_q} == count_q - 1'b1) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// wait until the last node has been compared
					if (!v_s1_q && !dv_s2) begin
						state_q <= S_FAR;
					end
				end
				S_FAR: begin
					if (D2_W'(lim_q) < best_d_q) begin
						state_q <= S_SQRT;
					end else begin
						for (int i = 0; i < 3; i++) begin
							new_q[i] <= smp_q[i];
						end
						state_q <= S_DONE;
					end
				end
				S_SQRT: begin
					if (sqrt_sts.done) begin
						state_q <= S_PROD;
					end
				end
				S_PROD: begin
					// offset magnitude times step for the current axis
					prod_q  <= axis_mag * step_q;
					neg_q   <= axis_diff[DIFF_W-1];
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (div_sts.done) begin
						new_q[axis_q] <= COORD_BITS'(DIFF_W'(near_q[axis_q]) + step_off);
						if (axis_q == 2'd2) begin
							state_q <= S_DONE;
						end else begin
							// next axis goes back through the product stage
							axis_q  <= axis_q + 1'b1;
							state_q <= S_PROD;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid  <= 1'b1;
						found      <= found_q;
						near_x     <= near_q[0];
						near_y     <= near_q[1];
						near_z     <= near_q[2];
						new_x      <= new_q[0];
						new_y      <= new_q[1];
						new_z      <= new_q[2];
						node_count <= count_q;
						dropped    <= dropped_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_NODES))
		else $error("node count beyond table size");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> node_count == CNT_W'(MAX_NODES))
		else $error("insert dropped while table not full");

	a_found_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> node_count != '0)
		else $error("query found a node in an empty table");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == S_IDLE)
		else $error("table written while busy");
endmodule
